[sv/assert_macros.svh]
// Shared assertion macros; clock i_clk, synchronous active-low reset i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[sv/llt_pkg.sv]
package llt_pkg;

    // Default sizing
    localparam int TABLE_DEPTH_DEF  = 256;
    localparam int SECTION_BITS_DEF = 8;

    // Operation codes
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_DEFINE = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;

    // Pass numbers with special behavior
    localparam logic [1:0] PASS_0 = 2'd0;
    localparam logic [1:0] PASS_2 = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_PHASE = 2'd2;
    localparam logic [1:0] STAT_UNDEF = 2'd3;

    // Reference kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_RELOC = 2'd1;
    localparam logic [1:0] KIND_ABS   = 2'd2;

    // Config register indexes
    localparam logic CFG_PASS = 1'b0;
    localparam logic CFG_ABS  = 1'b1;

    localparam logic [15:0] UNDEF_LOCATION = 16'hFFFF;
    localparam logic [7:0]  ABS_SECTION_RESET = 8'd1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CHECK,
        S_SCAN,
        S_EMIT
    } t_state;

    // One result item
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] location;
        logic [7:0]  section;
        logic [1:0]  kind;
    } t_result;

endpackage

[sv/local_label_table.sv]
// Steps: start, pass 0/1 define and unused codes go through execute and emit;
// a pass 2 define adds a check step and a find a scan step when there is an entry
// to read, comparing one entry per cycle through the single table read port.
// Throughput: one request at a time; the next is taken once the result moves
// to the output register, even while that register is stalled.
// Reset: synchronous active low; positions cleared, pass 0, absolute section 1.
module local_label_table #(
    parameter int TABLE_DEPTH  = llt_pkg::TABLE_DEPTH_DEF,
    parameter int SECTION_BITS = llt_pkg::SECTION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_operation,
    input  logic signed [15:0] i_label_number,
    input  logic [15:0]        i_location,
    input  logic [7:0]         i_section_id,
    input  logic               i_search_forward,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic [15:0]        o_found_location,
    output logic [7:0]         o_found_section,
    output logic [1:0]         o_reference_kind,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [1:0]        r_pass;
    logic [7:0]        r_abs_section;
    logic              r_out_valid;
    llt_pkg::t_result  r_out;

    logic              res_valid;
    logic              res_take;
    llt_pkg::t_result  res;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [15:0]             mem_wlabel;
    logic [15:0]             mem_wlocation;
    logic [SECTION_BITS-1:0] mem_wsection;
    logic                    mem_re;
    logic [AW-1:0]           mem_raddr;
    logic [15:0]             mem_rlabel;
    logic [15:0]             mem_rlocation;
    logic [SECTION_BITS-1:0] mem_rsection;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass        <= llt_pkg::PASS_0;
            r_abs_section <= llt_pkg::ABS_SECTION_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                llt_pkg::CFG_PASS: r_pass        <= i_cfg_data[1:0];
                llt_pkg::CFG_ABS:  r_abs_section <= i_cfg_data;
                default:           r_pass        <= r_pass;
            endcase
        end
    end

    llt_seq #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .SECTION_BITS (SECTION_BITS)
    ) u_seq (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_operation           (i_operation),
        .i_label_number        (i_label_number),
        .i_location            (i_location),
        .i_section_id          (i_section_id),
        .i_search_forward      (i_search_forward),
        .i_pass_number         (r_pass),
        .i_absolute_section_id (r_abs_section),
        .o_res_valid           (res_valid),
        .i_res_take            (res_take),
        .o_res                 (res),
        .o_mem_we              (mem_we),
        .o_mem_waddr           (mem_waddr),
        .o_mem_wlabel          (mem_wlabel),
        .o_mem_wlocation       (mem_wlocation),
        .o_mem_wsection        (mem_wsection),
        .o_mem_re              (mem_re),
        .o_mem_raddr           (mem_raddr),
        .i_mem_rlabel          (mem_rlabel),
        .i_mem_rlocation       (mem_rlocation),
        .i_mem_rsection        (mem_rsection)
    );

    llt_mem #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .SECTION_BITS (SECTION_BITS)
    ) u_mem (
        .i_clk       (i_clk),
        .i_we        (mem_we),
        .i_waddr     (mem_waddr),
        .i_wlabel    (mem_wlabel),
        .i_wlocation (mem_wlocation),
        .i_wsection  (mem_wsection),
        .i_re        (mem_re),
        .i_raddr     (mem_raddr),
        .o_rlabel    (mem_rlabel),
        .o_rlocation (mem_rlocation),
        .o_rsection  (mem_rsection)
    );

    // Output register: takes a result whenever it is empty or draining
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) r_out <= res;
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_found_location = r_out.location;
    assign o_found_section  = r_out.section;
    assign o_reference_kind = r_out.kind;

endmodule

[sv/llt_mem.sv]
module llt_mem #(
    parameter int TABLE_DEPTH  = llt_pkg::TABLE_DEPTH_DEF,
    parameter int SECTION_BITS = llt_pkg::SECTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_waddr,
    input  logic [15:0]                   i_wlabel,
    input  logic [15:0]                   i_wlocation,
    input  logic [SECTION_BITS-1:0]       i_wsection,
    input  logic                          i_re,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_raddr,
    output logic [15:0]                   o_rlabel,
    output logic [15:0]                   o_rlocation,
    output logic [SECTION_BITS-1:0]       o_rsection
);

    logic [15:0]             r_label_mem    [TABLE_DEPTH];
    logic [15:0]             r_location_mem [TABLE_DEPTH];
    logic [SECTION_BITS-1:0] r_section_mem  [TABLE_DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_label_mem[i_waddr]    <= i_wlabel;
            r_location_mem[i_waddr] <= i_wlocation;
            r_section_mem[i_waddr]  <= i_wsection;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rlabel    <= r_label_mem[i_raddr];
            o_rlocation <= r_location_mem[i_raddr];
            o_rsection  <= r_section_mem[i_raddr];
        end
    end

endmodule

[sv/llt_seq.sv]
`include "assert_macros.svh"

module llt_seq #(
    parameter int TABLE_DEPTH  = llt_pkg::TABLE_DEPTH_DEF,
    parameter int SECTION_BITS = llt_pkg::SECTION_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request side
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_operation,
    input  logic signed [15:0]             i_label_number,
    input  logic [15:0]                    i_location,
    input  logic [7:0]                     i_section_id,
    input  logic                           i_search_forward,
    // configuration
    input  logic [1:0]                     i_pass_number,
    input  logic [7:0]                     i_absolute_section_id,
    // result handoff
    output logic                           o_res_valid,
    input  logic                           i_res_take,
    output llt_pkg::t_result               o_res,
    // table memory
    output logic                           o_mem_we,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_mem_waddr,
    output logic [15:0]                    o_mem_wlabel,
    output logic [15:0]                    o_mem_wlocation,
    output logic [SECTION_BITS-1:0]        o_mem_wsection,
    output logic                           o_mem_re,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_mem_raddr,
    input  logic [15:0]                    i_mem_rlabel,
    input  logic [15:0]                    i_mem_rlocation,
    input  logic [SECTION_BITS-1:0]        i_mem_rsection
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = $clog2(TABLE_DEPTH + 1);
    localparam logic [PW-1:0] DEPTH_P = PW'(TABLE_DEPTH);
    localparam logic [PW-1:0] ONE_P   = PW'(1);

    llt_pkg::t_state  r_state, n_state;
    logic [1:0]       r_op;
    logic [15:0]      r_label;
    logic [15:0]      r_location;
    logic [SECTION_BITS-1:0] r_section;
    logic             r_forward;
    logic [PW-1:0]    r_cur, n_cur;
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_hm, n_hm;
    logic [PW-1:0]    r_pos, n_pos;
    llt_pkg::t_result r_res, n_res;

    logic [15:0]             sec_ext;
    logic [15:0]             rsec_ext;
    logic                    cur_full;
    logic                    wp_full;
    logic                    label_hit;
    logic                    fwd_start;
    logic                    bwd_start;
    logic                    scan_more;
    logic [PW-1:0]           cur_dec;
    logic [PW-1:0]           pos_dec;
    llt_pkg::t_result        res_ok;
    llt_pkg::t_result        res_full;
    llt_pkg::t_result        res_undef;
    llt_pkg::t_result        res_found;

    // Shared compare and step logic
    assign sec_ext   = 16'(i_section_id);
    assign rsec_ext  = 16'(i_mem_rsection);
    assign cur_full  = (r_cur == DEPTH_P);
    assign wp_full   = (r_wp == DEPTH_P);
    assign label_hit = (i_mem_rlabel == r_label);
    assign fwd_start = (r_cur < r_hm);
    assign bwd_start = (r_cur != '0);
    assign scan_more = r_forward ? (r_pos < r_hm) : (r_pos != '0);
    assign cur_dec   = r_cur - ONE_P;
    assign pos_dec   = r_pos - ONE_P;

    // Canned result items
    assign res_ok    = '{status: llt_pkg::STAT_OK, location: 16'd0, section: 8'd0,
                         kind: llt_pkg::KIND_NONE};
    assign res_full  = '{status: llt_pkg::STAT_FULL, location: 16'd0, section: 8'd0,
                         kind: llt_pkg::KIND_NONE};
    assign res_undef = '{status: llt_pkg::STAT_UNDEF, location: llt_pkg::UNDEF_LOCATION,
                         section: i_absolute_section_id, kind: llt_pkg::KIND_ABS};
    assign res_found = '{status: llt_pkg::STAT_OK, location: i_mem_rlocation,
                         section: rsec_ext[7:0],
                         kind: (i_mem_rsection != '0) ? llt_pkg::KIND_RELOC
                                                      : llt_pkg::KIND_NONE};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            llt_pkg::S_IDLE: begin
                if (i_in_valid) n_state = llt_pkg::S_EXEC;
            end
            llt_pkg::S_EXEC: begin
                n_state = llt_pkg::S_EMIT;
                case (r_op)
                    llt_pkg::OP_DEFINE: begin
                        if (i_pass_number == llt_pkg::PASS_2 && !cur_full)
                            n_state = llt_pkg::S_CHECK;
                    end
                    llt_pkg::OP_FIND: begin
                        if (r_forward ? fwd_start : bwd_start)
                            n_state = llt_pkg::S_SCAN;
                    end
                    default: n_state = llt_pkg::S_EMIT;
                endcase
            end
            llt_pkg::S_CHECK: n_state = llt_pkg::S_EMIT;
            llt_pkg::S_SCAN: begin
                if (label_hit || !scan_more) n_state = llt_pkg::S_EMIT;
            end
            llt_pkg::S_EMIT: begin
                if (i_res_take) n_state = llt_pkg::S_IDLE;
            end
            default: n_state = llt_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_cur           = r_cur;
        n_wp            = r_wp;
        n_hm            = r_hm;
        n_pos           = r_pos;
        n_res           = r_res;
        o_mem_we        = 1'b0;
        o_mem_waddr     = r_wp[AW-1:0];
        o_mem_wlabel    = r_label;
        o_mem_wlocation = r_location;
        o_mem_wsection  = r_section;
        o_mem_re        = 1'b0;
        o_mem_raddr     = r_cur[AW-1:0];
        case (r_state)
            llt_pkg::S_EXEC: begin
                case (r_op)
                    llt_pkg::OP_START: begin
                        n_cur = '0;
                        if (i_pass_number != llt_pkg::PASS_2) n_wp = '0;
                        if (i_pass_number == llt_pkg::PASS_0) n_hm = '0;
                        n_res = res_ok;
                    end
                    llt_pkg::OP_DEFINE: begin
                        if (!cur_full) n_cur = r_cur + ONE_P;
                        if (i_pass_number != llt_pkg::PASS_2) begin
                            // append entry
                            if (wp_full) begin
                                n_res = res_full;
                            end else begin
                                o_mem_we = 1'b1;
                                n_wp     = r_wp + ONE_P;
                                if (i_pass_number == llt_pkg::PASS_0) n_hm = r_wp + ONE_P;
                                n_res    = res_ok;
                            end
                        end else begin
                            // fetch stored entry for the phase check
                            n_res = res_full;
                            if (!cur_full) o_mem_re = 1'b1;
                        end
                    end
                    llt_pkg::OP_FIND: begin
                        n_res = res_undef;
                        if (r_forward) begin
                            if (fwd_start) begin
                                o_mem_re = 1'b1;
                                n_pos    = r_cur + ONE_P;
                            end
                        end else if (bwd_start) begin
                            o_mem_re    = 1'b1;
                            o_mem_raddr = cur_dec[AW-1:0];
                            n_pos       = cur_dec;
                        end
                    end
                    default: n_res = res_ok;
                endcase
            end
            llt_pkg::S_CHECK: begin
                n_res = (i_mem_rlocation == r_location) ? res_ok
                      : '{status: llt_pkg::STAT_PHASE, location: 16'd0, section: 8'd0,
                          kind: llt_pkg::KIND_NONE};
            end
            llt_pkg::S_SCAN: begin
                // one entry compared per cycle, next read issued alongside
                if (label_hit) begin
                    n_res = res_found;
                end else if (scan_more) begin
                    o_mem_re = 1'b1;
                    if (r_forward) begin
                        o_mem_raddr = r_pos[AW-1:0];
                        n_pos       = r_pos + ONE_P;
                    end else begin
                        o_mem_raddr = pos_dec[AW-1:0];
                        n_pos       = pos_dec;
                    end
                end else begin
                    n_res = res_undef;
                end
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= llt_pkg::S_IDLE;
            r_cur   <= '0;
            r_wp    <= '0;
            r_hm    <= '0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_wp    <= n_wp;
            r_hm    <= n_hm;
            r_pos   <= n_pos;
        end
    end

    // Request and result payload
    always_ff @(posedge i_clk) begin
        if (r_state == llt_pkg::S_IDLE && i_in_valid) begin
            r_op       <= i_operation;
            r_label    <= i_label_number;
            r_location <= i_location;
            r_section  <= sec_ext[SECTION_BITS-1:0];
            r_forward  <= i_search_forward;
        end
        r_res <= n_res;
    end

    assign o_in_stall  = (r_state != llt_pkg::S_IDLE);
    assign o_res_valid = (r_state == llt_pkg::S_EMIT);
    assign o_res       = r_res;

    `ASSERT_ALWAYS(a_wp_bound, r_wp <= DEPTH_P && r_hm <= DEPTH_P && r_cur <= DEPTH_P,
        "table position beyond depth")
    `ASSERT_ALWAYS(a_write_in_exec, !o_mem_we || r_state == llt_pkg::S_EXEC,
        "table write outside execute step")
    `ASSERT_NEXT(a_res_hold, r_state == llt_pkg::S_EMIT && !i_res_take,
        r_state == llt_pkg::S_EMIT && $stable(r_res), "pending result changed")
    `ASSERT_NEXT(a_check_after_read, r_state == llt_pkg::S_EXEC && r_op == llt_pkg::OP_DEFINE
        && i_pass_number == llt_pkg::PASS_2 && !cur_full,
        r_state == llt_pkg::S_CHECK && $past(o_mem_re), "phase check without read")

endmodule

[tb/tb_local_label_table.sv]
`timescale 1ns / 100ps

module tb_local_label_table;

    localparam int DEPTH       = llt_pkg::TABLE_DEPTH_DEF;
    localparam int WATCH_LIMIT = 4000;
    localparam int RAND_ITEMS  = 1950;
    localparam int CALM_FROM   = 1750;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] PASS_1    = 2'd1;
    localparam logic [1:0] PASS_3    = 2'd3;

    // Replies known at a glance
    localparam llt_pkg::t_result RES_OK =
        '{llt_pkg::STAT_OK, 16'h0000, 8'h00, llt_pkg::KIND_NONE};
    localparam llt_pkg::t_result RES_PHASE =
        '{llt_pkg::STAT_PHASE, 16'h0000, 8'h00, llt_pkg::KIND_NONE};
    localparam llt_pkg::t_result RES_UNDEF_RST =
        '{llt_pkg::STAT_UNDEF, llt_pkg::UNDEF_LOCATION, llt_pkg::ABS_SECTION_RESET,
          llt_pkg::KIND_ABS};
    localparam llt_pkg::t_result RES_UNDEF_FF =
        '{llt_pkg::STAT_UNDEF, llt_pkg::UNDEF_LOCATION, 8'hFF, llt_pkg::KIND_ABS};

    typedef struct {
        logic [1:0]  op;
        logic [15:0] label;
        logic [15:0] loc;
        logic [7:0]  sec;
        logic        fwd;
    } t_lbl_req;

    typedef struct {
        bit               is_cfg;
        logic             cfg_idx;
        logic [7:0]       cfg_val;
        t_lbl_req         req;
        bit               typed;
        llt_pkg::t_result reply;
    } t_plan_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_operation;
    logic signed [15:0] i_label_number;
    logic [15:0]        i_location;
    logic [7:0]         i_section_id;
    logic               i_search_forward;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [1:0]         o_status;
    logic [15:0]        o_found_location;
    logic [7:0]         o_found_section;
    logic [1:0]         o_reference_kind;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [7:0]         i_cfg_data;

    // Shadow of the label table and its registers
    logic [15:0] tbl_label   [DEPTH];
    logic [15:0] tbl_loc     [DEPTH];
    logic [7:0]  tbl_sec     [DEPTH];
    bit          tbl_written [DEPTH];
    int          cur_pos     = 0;
    int          wr_pos      = 0;
    int          high_mark   = 0;
    logic [1:0]  pass_reg    = llt_pkg::PASS_0;
    logic [7:0]  abs_sec_reg = llt_pkg::ABS_SECTION_RESET;

    llt_pkg::t_result due_replies [$];
    llt_pkg::t_result want_reply;
    t_lbl_req         prog_items  [$];
    int       items_sent    = 0;
    int       fail_count    = 0;
    int       quiet_cycles  = 0;
    bit       send_gaps     = 1'b1;
    bit       calm_tail     = 1'b0;
    bit       long_hold_req = 1'b0;

    local_label_table u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_label_number   (i_label_number),
        .i_location       (i_location),
        .i_section_id     (i_section_id),
        .i_search_forward (i_search_forward),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_found_location (o_found_location),
        .o_found_section  (o_found_section),
        .o_reference_kind (o_reference_kind),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // 100 MHz clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic llt_pkg::t_result entry_reply(int idx);
        llt_pkg::t_result r;
        r.status   = llt_pkg::STAT_OK;
        r.location = tbl_loc[idx];
        r.section  = tbl_sec[idx];
        r.kind     = (tbl_sec[idx] == 8'h00) ? llt_pkg::KIND_NONE : llt_pkg::KIND_RELOC;
        return r;
    endfunction

    // Apply one request to the shadow table and return the reply it produces
    function automatic llt_pkg::t_result label_table_reply(t_lbl_req q);
        llt_pkg::t_result r;
        int      pos;
        bit      at_end;
        r = RES_OK;
        case (q.op)
            llt_pkg::OP_START: begin
                cur_pos = 0;
                if (pass_reg != llt_pkg::PASS_2) wr_pos = 0;
                if (pass_reg == llt_pkg::PASS_0) high_mark = 0;
            end
            llt_pkg::OP_DEFINE: begin
                at_end = (cur_pos >= DEPTH);
                if (!at_end) cur_pos++;
                if (pass_reg != llt_pkg::PASS_2) begin
                    // passes 0, 1 and 3 append
                    if (wr_pos >= DEPTH) begin
                        r.status = llt_pkg::STAT_FULL;
                    end else begin
                        tbl_label[wr_pos]   = q.label;
                        tbl_loc[wr_pos]     = q.loc;
                        tbl_sec[wr_pos]     = q.sec;
                        tbl_written[wr_pos] = 1'b1;
                        wr_pos++;
                        if (pass_reg == llt_pkg::PASS_0) high_mark = wr_pos;
                    end
                end else if (at_end) begin
                    r.status = llt_pkg::STAT_FULL;
                end else if (tbl_loc[cur_pos - 1] != q.loc) begin
                    r.status = llt_pkg::STAT_PHASE;
                end
            end
            llt_pkg::OP_FIND: begin
                if (q.fwd) begin
                    for (pos = cur_pos; pos < high_mark; pos++)
                        if (tbl_label[pos] == q.label) return entry_reply(pos);
                end else begin
                    for (pos = cur_pos - 1; pos >= 0; pos--)
                        if (tbl_label[pos] == q.label) return entry_reply(pos);
                end
                r = '{llt_pkg::STAT_UNDEF, llt_pkg::UNDEF_LOCATION, abs_sec_reg,
                      llt_pkg::KIND_ABS};
            end
            default: ;
        endcase
        return r;
    endfunction

    // True when the request would compare against an entry never written
    function automatic bit reads_unwritten_entry(t_lbl_req q);
        int pos;
        if (q.op == llt_pkg::OP_DEFINE)
            return pass_reg == llt_pkg::PASS_2 && cur_pos < DEPTH && !tbl_written[cur_pos];
        if (q.op != llt_pkg::OP_FIND) return 1'b0;
        if (q.fwd) begin
            for (pos = cur_pos; pos < high_mark; pos++) begin
                if (!tbl_written[pos]) return 1'b1;
                if (tbl_label[pos] == q.label) return 1'b0;
            end
        end else begin
            for (pos = cur_pos - 1; pos >= 0; pos--) begin
                if (!tbl_written[pos]) return 1'b1;
                if (tbl_label[pos] == q.label) return 1'b0;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_plan_row mk_req(logic [1:0] op, logic [15:0] label, logic [15:0] loc,
                                         logic [7:0] sec, logic fwd, bit typed,
                                         llt_pkg::t_result reply);
        t_plan_row row;
        row.is_cfg  = 1'b0;
        row.cfg_idx = llt_pkg::CFG_PASS;
        row.cfg_val = 8'h00;
        row.req     = '{op, label, loc, sec, fwd};
        row.typed   = typed;
        row.reply   = reply;
        return row;
    endfunction

    function automatic t_plan_row mk_cfg(logic idx, logic [7:0] val);
        t_plan_row row;
        row         = mk_req(llt_pkg::OP_START, 16'h0, 16'h0, 8'h0, 1'b0, 1'b0, RES_OK);
        row.is_cfg  = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val;
        return row;
    endfunction

    // Offer one request, wait for it to be taken, record its reply
    task automatic send_request(t_lbl_req q, bit typed, llt_pkg::t_result typed_reply);
        llt_pkg::t_result r;
        @(negedge i_clk);
        if (send_gaps && !calm_tail && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_operation      <= q.op;
        i_label_number   <= q.label;
        i_location       <= q.loc;
        i_section_id     <= q.sec;
        i_search_forward <= q.fwd;
        i_in_valid       <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        r = label_table_reply(q);
        due_replies.push_back(typed ? typed_reply : r);
        if (q.op != OP_UNUSED) items_sent++;
        if (items_sent == HOLD_AT) long_hold_req = 1'b1;
        if (items_sent >= CALM_FROM) calm_tail = 1'b1;
    endtask

    task automatic try_send(t_lbl_req q);
        if (!reads_unwritten_entry(q)) send_request(q, 1'b0, RES_OK);
    endtask

    // Register write once the block has drained
    task automatic write_cfg(logic idx, logic [7:0] val);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_replies.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == llt_pkg::CFG_PASS) pass_reg = val[1:0];
        else abs_sec_reg = val;
    endtask

    // One assembler pass over the current program, with some noise mixed in
    task automatic run_pass(logic [1:0] pass);
        t_lbl_req q;
        int       stop_at;
        int       k;
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
                0:       write_cfg(llt_pkg::CFG_ABS, 8'h00);
                1:       write_cfg(llt_pkg::CFG_ABS, 8'hFF);
                default: write_cfg(llt_pkg::CFG_ABS, 8'($urandom));
            endcase
        end
        write_cfg(llt_pkg::CFG_PASS, {6'd0, pass});
        send_gaps = ($urandom_range(0, 3) != 0);
        q = '{llt_pkg::OP_START, 16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom)};
        try_send(q);
        // now and then a pass is cut short
        stop_at = ($urandom_range(0, 15) == 0) ? $urandom_range(0, prog_items.size())
                                               : prog_items.size();
        for (k = 0; k < stop_at; k++) begin
            if ($urandom_range(0, 19) == 0) begin
                q = '{2'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom)};
                try_send(q);
            end
            q = prog_items[k];
            if (q.op == llt_pkg::OP_DEFINE && pass != llt_pkg::PASS_0 &&
                $urandom_range(0, 15) == 0)
                q.loc = q.loc + 16'($urandom_range(1, 3));
            try_send(q);
        end
    endtask

    // Reply checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_replies.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected reply: status %0d loc %h sec %h kind %0d",
                             o_status, o_found_location, o_found_section, o_reference_kind);
            end else begin
                want_reply = due_replies.pop_front();
                if (o_status !== want_reply.status || o_found_location !== want_reply.location ||
                    o_found_section !== want_reply.section ||
                    o_reference_kind !== want_reply.kind) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"reply mismatch: expected status %0d loc %h sec %h kind %0d, ",
                                  "got status %0d loc %h sec %h kind %0d"},
                                 want_reply.status, want_reply.location, want_reply.section,
                                 want_reply.kind, o_status, o_found_location,
                                 o_found_section, o_reference_kind);
                end
            end
        end
    end

    // Watchdog on cycles with no request and no reply taken
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off, calm at the end
    initial begin
        int burst;
        bit stall_now;
        i_out_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (calm_tail) begin
                i_out_stall <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                burst = $urandom_range(1, 15);
                if ($urandom_range(0, 15) == 0) begin
                    stall_now = 1'b0;
                    burst     = $urandom_range(60, 150);
                end else begin
                    stall_now = ($urandom_range(0, 1) == 0);
                end
                i_out_stall <= stall_now;
                repeat (burst - 1) @(negedge i_clk);
            end
        end
    end

    // Stimulus
    initial begin
        t_plan_row   plan [$];
        t_lbl_req    q;
        logic [15:0] base;
        logic [15:0] loc;
        logic [7:0]  sec;
        int          n_defs;
        int          defs;
        int          prog_count;
        bit          big;

        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_operation      <= llt_pkg::OP_START;
        i_label_number   <= 16'sd0;
        i_location       <= 16'h0000;
        i_section_id     <= 8'h00;
        i_search_forward <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= llt_pkg::CFG_PASS;
        i_cfg_data       <= 8'h00;

        // empty table, extremes, then each pass with its special cases
        plan.push_back(mk_req(llt_pkg::OP_FIND, 16'h0005, 16'h0000, 8'h00, 1'b0, 1'b1,
                              RES_UNDEF_RST));
        plan.push_back(mk_req(llt_pkg::OP_FIND, 16'h0005, 16'h0000, 8'h00, 1'b1, 1'b1,
                              RES_UNDEF_RST));
        plan.push_back(mk_req(OP_UNUSED, 16'h7FFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1, RES_OK));
        plan.push_back(mk_req(llt_pkg::OP_START, 16'h8000, 16'hFFFF, 8'hFF, 1'b1, 1'b1,
                              RES_OK));
        plan.push_back(mk_req(llt_pkg::OP_DEFINE, 16'h7FFF, 16'hFFFF, 8'hFF, 1'b0, 1'b1,
                              RES_OK));
        plan.push_back(mk_req(llt_pkg::OP_DEFINE, 16'h8000, 16'h0000, 8'h00, 1'b1, 1'b1,
                              RES_OK));
        plan.push_back(mk_req(llt_pkg::OP_DEFINE, 16'h0005, 16'h1234, 8'h03, 1'b0, 1'b1,
                              RES_OK));
        plan.push_back(mk_req(llt_pkg::OP_FIND, 16'h7FFF, 16'h0000, 8'h00, 1'b0, 1'b1,
                              '{llt_pkg::STAT_OK, 16'hFFFF, 8'hFF, llt_pkg::KIND_RELOC}));
        plan.push_back(mk_req(llt_pkg::OP_FIND, 16'h8000, 16'h0000, 8'h00, 1'b0, 1'b1,
                              '{llt_pkg::STAT_OK, 16'h0000, 8'h00, llt_pkg::KIND_NONE}));
        // forward find from the high mark
        plan.push_back(mk_req(llt_pkg::OP_FIND, 16'h0005, 16'h0000, 8'h00, 1'b1, 1'b1,
                              RES_UNDEF_RST));
        plan.push_back(mk_cfg(llt_pkg::CFG_PASS, {6'd0, PASS_1}));
        plan.push_back(mk_req(llt_pkg::OP_START, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0,
                              RES_OK));
        plan.push_back(mk_req(llt_pkg::OP_FIND, 16'h0005, 16'h0000, 8'h00, 1'b1, 1'b0,
                              RES_OK));
        plan.push_back(mk_req(llt_pkg::OP_DEFINE, 16'h0005, 16'h1234, 8'h03, 1'b0, 1'b0,
                              RES_OK));
        plan.push_back(mk_req(llt_pkg::OP_FIND, 16'h0005, 16'h0000, 8'h00, 1'b1, 1'b0,
                              RES_OK));
        plan.push_back(mk_cfg(llt_pkg::CFG_ABS, 8'hFF));
        plan.push_back(mk_cfg(llt_pkg::CFG_PASS, {6'd0, llt_pkg::PASS_2}));
        plan.push_back(mk_req(llt_pkg::OP_START, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0,
                              RES_OK));
        plan.push_back(mk_req(llt_pkg::OP_DEFINE, 16'h0005, 16'h1234, 8'h03, 1'b0, 1'b0,
                              RES_OK));
        // location moved since the earlier pass
        plan.push_back(mk_req(llt_pkg::OP_DEFINE, 16'h8000, 16'h0001, 8'h00, 1'b0, 1'b1,
                              RES_PHASE));
        plan.push_back(mk_req(llt_pkg::OP_FIND, 16'h0009, 16'h0000, 8'h00, 1'b0, 1'b1,
                              RES_UNDEF_FF));
        plan.push_back(mk_cfg(llt_pkg::CFG_ABS, 8'h00));
        // pass 3 acts as pass 1
        plan.push_back(mk_cfg(llt_pkg::CFG_PASS, {6'd0, PASS_3}));
        plan.push_back(mk_req(llt_pkg::OP_START, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0,
                              RES_OK));
        plan.push_back(mk_req(llt_pkg::OP_DEFINE, 16'h1234, 16'hBEEF, 8'h80, 1'b0, 1'b0,
                              RES_OK));
        plan.push_back(mk_req(llt_pkg::OP_FIND, 16'h1234, 16'h0000, 8'h00, 1'b0, 1'b0,
                              RES_OK));
        plan.push_back(mk_req(llt_pkg::OP_FIND, 16'h0005, 16'h0000, 8'h00, 1'b1, 1'b0,
                              RES_OK));
        plan.push_back(mk_req(OP_UNUSED, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b1, RES_OK));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].is_cfg) write_cfg(plan[k].cfg_idx, plan[k].cfg_val);
            else send_request(plan[k].req, plan[k].typed, plan[k].reply);
        end

        // Random programs: labels from a small pool so finds hit nearby entries.
        // One large program overflows the table in pass 0 and runs off its end in pass 2.
        prog_count = 0;
        while (items_sent < RAND_ITEMS) begin
            big    = (prog_count == 2);
            n_defs = big ? $urandom_range(258, 264) : $urandom_range(1, 40);
            base   = 16'($urandom);
            loc    = 16'($urandom);
            sec    = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
            defs   = 0;
            prog_items.delete();
            while (defs < n_defs) begin
                q.label = base + 16'($urandom_range(0, 7));
                q.sec   = sec;
                q.fwd   = 1'($urandom);
                if ($urandom_range(0, 9) < (big ? 9 : 7)) begin
                    q.op  = llt_pkg::OP_DEFINE;
                    q.loc = loc;
                    loc   = loc + 16'($urandom_range(0, 20));
                    defs++;
                    if ($urandom_range(0, 15) == 0)
                        sec = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom);
                end else begin
                    q.op  = llt_pkg::OP_FIND;
                    q.loc = 16'($urandom);
                end
                prog_items.push_back(q);
            end
            run_pass(llt_pkg::PASS_0);
            if (!big && $urandom_range(0, 3) != 0)
                run_pass(($urandom_range(0, 3) == 0) ? PASS_3 : PASS_1);
            run_pass(llt_pkg::PASS_2);
            prog_count++;
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_replies.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        fail_count += due_replies.size();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
